[rtl/fds_pkg.sv]
package fds_pkg;

   // Phase codes
   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_FREEFALL = 2'd1,
      PH_IMPACT   = 2'd2,
      PH_CONFIRM  = 2'd3
   } phase_type;

   // Item kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_CLEAR  = 1'b1;

   // Register indexes
   localparam int          CSR_COUNT       = 7;
   localparam int          CSR_IDX_W       = $clog2(CSR_COUNT + 1);
   localparam int          CSR_DATA_W      = 24;
   localparam logic [2:0]  CSR_ENABLE      = 3'd0;
   localparam logic [2:0]  CSR_FREEFALL_MG = 3'd1;
   localparam logic [2:0]  CSR_IMPACT_MG   = 3'd2;
   localparam logic [2:0]  CSR_FF_WINDOW   = 3'd3;
   localparam logic [2:0]  CSR_CONFIRM_MS  = 3'd4;
   localparam logic [2:0]  CSR_COOLDOWN_MS = 3'd5;
   localparam logic [2:0]  CSR_TILT_DEG10  = 3'd6;

   // Register reset values
   localparam logic        ENABLE_RESET      = 1'b1;
   localparam logic [15:0] FREEFALL_MG_RESET = 16'd400;
   localparam logic [15:0] IMPACT_MG_RESET   = 16'd2500;
   localparam logic [15:0] FF_WINDOW_RESET   = 16'd100;
   localparam logic [15:0] CONFIRM_MS_RESET  = 16'd2000;
   localparam logic [23:0] COOLDOWN_MS_RESET = 24'd10000;
   localparam logic [9:0]  TILT_DEG10_RESET  = 10'd600;

   // Fixed timing and margins
   localparam logic [16:0] SHAKE_MARGIN_MG   = 17'd200;
   localparam logic [16:0] FREEFALL_EXTRA_MS = 17'd300;
   localparam logic [31:0] IMPACT_WINDOW_MS  = 32'd500;
   localparam logic [9:0]  ANGLE_FULL        = 10'd900;
   localparam logic [6:0]  SINE_FULL         = 7'd100;

   // Angle to sine table, segments are 15 deg wide (150 in tenths)
   localparam logic [9:0] ANGLE_PTS [7] = '{10'd0, 10'd150, 10'd300, 10'd450,
                                            10'd600, 10'd750, 10'd900};
   localparam logic [6:0] SINE_PTS [7]  = '{7'd0, 7'd26, 7'd50, 7'd71,
                                            7'd87, 7'd97, 7'd100};
   // x/150 == (x*437)>>16 for every product below 4096
   localparam logic [9:0] SPAN_RECIP = 10'd437;
   localparam int         SPAN_SHIFT = 16;

   typedef struct packed {
      logic        kind;
      logic        sample_valid;
      logic [15:0] accel_mag_mg;
      logic [6:0]  tilt_sine_pct;
      logic [31:0] time_ms;
   } item_type;

   typedef struct packed {
      logic        fall_detected;
      phase_type   phase;
      logic [31:0] fall_total;
      logic        cooling_down;
   } result_type;

   typedef struct packed {
      logic        enable;
      logic [15:0] freefall_mg;
      logic [15:0] impact_mg;
      logic [15:0] freefall_window_ms;
      logic [15:0] confirm_ms;
      logic [23:0] cooldown_ms;
      logic [6:0]  tilt_th;
   } cfg_type;

   function automatic logic [6:0] sine_of_angle(input logic [9:0] a);
      logic [6:0]  base;
      logic [4:0]  rise;
      logic [9:0]  d;
      logic [11:0] prod;
      logic [21:0] q;
      logic        found;
      logic [6:0]  res;
      base  = '0;
      rise  = '0;
      d     = '0;
      found = 1'b0;
      for (int k = 0; k < 6; k++) begin
         if (!found && a <= ANGLE_PTS[k+1]) begin
            found = 1'b1;
            base  = SINE_PTS[k];
            rise  = 5'(SINE_PTS[k+1] - SINE_PTS[k]);
            d     = a - ANGLE_PTS[k];
         end
      end
      prod = 12'(rise * d);
      q    = 22'(prod * SPAN_RECIP);
      res  = base + 7'(q >> SPAN_SHIFT);
      if (a >= ANGLE_FULL) begin
         res = SINE_FULL;
      end
      return res;
   endfunction

   localparam logic [6:0] TILT_TH_RESET = sine_of_angle(TILT_DEG10_RESET);

endpackage

[rtl/fds_csr.sv]
module fds_csr
   import fds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ENABLE:      cfg_in.enable             = csr_data[0];
            CSR_FREEFALL_MG: cfg_in.freefall_mg        = csr_data[15:0];
            CSR_IMPACT_MG:   cfg_in.impact_mg          = csr_data[15:0];
            CSR_FF_WINDOW:   cfg_in.freefall_window_ms = csr_data[15:0];
            CSR_CONFIRM_MS:  cfg_in.confirm_ms         = csr_data[15:0];
            CSR_COOLDOWN_MS: cfg_in.cooldown_ms        = csr_data[23:0];
            // angle is kept only as its sine threshold
            CSR_TILT_DEG10:  cfg_in.tilt_th            = sine_of_angle(csr_data[9:0]);
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable             <= ENABLE_RESET;
         cfg_ff.freefall_mg        <= FREEFALL_MG_RESET;
         cfg_ff.impact_mg          <= IMPACT_MG_RESET;
         cfg_ff.freefall_window_ms <= FF_WINDOW_RESET;
         cfg_ff.confirm_ms         <= CONFIRM_MS_RESET;
         cfg_ff.cooldown_ms        <= COOLDOWN_MS_RESET;
         cfg_ff.tilt_th            <= TILT_TH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/fds_engine.sv]
module fds_engine
   import fds_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] cool_end_ff, cool_end_in;
   logic        armed_ff, armed_in;
   logic [31:0] count_ff, count_in;

   logic        is_clear;
   logic        cooling;
   logic        live;
   logic [31:0] cool_diff;
   logic [31:0] since;
   logic [16:0] shake_lim;
   logic [16:0] ff_timeout;
   logic        tilt_hit;
   logic        pulse;
   logic        start_ld;
   logic [31:0] cool_left;

   assign is_clear   = (item.kind == KIND_CLEAR);
   assign cool_diff  = item.time_ms - cool_end_ff;
   assign cooling    = armed_ff && cool_diff[31];
   assign live       = !is_clear && cfg.enable && item.sample_valid && !cooling;
   assign since      = item.time_ms - start_ff;
   assign shake_lim  = {1'b0, cfg.freefall_mg} + SHAKE_MARGIN_MG;
   assign ff_timeout = {1'b0, cfg.freefall_window_ms} + FREEFALL_EXTRA_MS;
   assign tilt_hit   = (item.tilt_sine_pct >= cfg.tilt_th);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (is_clear) begin
         phase_in = PH_IDLE;
      end else if (live) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (item.accel_mag_mg < cfg.freefall_mg) phase_in = PH_FREEFALL;
            end
            PH_FREEFALL: begin
               if (item.accel_mag_mg > cfg.impact_mg) begin
                  phase_in = PH_IMPACT;
               end else if ({1'b0, item.accel_mag_mg} > shake_lim) begin
                  phase_in = PH_IDLE;
               end else if (since >= {15'b0, ff_timeout}) begin
                  phase_in = PH_IDLE;
               end
            end
            PH_IMPACT: begin
               if (tilt_hit) begin
                  phase_in = PH_CONFIRM;
               end else if (since >= IMPACT_WINDOW_MS) begin
                  phase_in = PH_IDLE;
               end
            end
            PH_CONFIRM: begin
               if (!tilt_hit || since >= {16'b0, cfg.confirm_ms}) phase_in = PH_IDLE;
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   // machine outputs
   always_comb begin
      pulse    = 1'b0;
      start_ld = 1'b0;
      if (live) begin
         unique case (phase_ff)
            PH_IDLE:     start_ld = (item.accel_mag_mg < cfg.freefall_mg);
            PH_FREEFALL: start_ld = (item.accel_mag_mg > cfg.impact_mg);
            PH_IMPACT:   start_ld = tilt_hit;
            PH_CONFIRM:  pulse    = tilt_hit && (since >= {16'b0, cfg.confirm_ms});
            default:     start_ld = 1'b0;
         endcase
      end
   end

   always_comb begin
      start_in    = start_ld ? item.time_ms : start_ff;
      count_in    = count_ff + {31'b0, pulse};
      cool_end_in = cool_end_ff;
      armed_in    = armed_ff;
      if (is_clear) begin
         cool_end_in = '0;
         armed_in    = 1'b0;
      end else if (pulse) begin
         cool_end_in = item.time_ms + {8'b0, cfg.cooldown_ms};
         armed_in    = 1'b1;
      end else if (!cooling) begin
         armed_in    = 1'b0;   // window expired
      end
   end

   assign cool_left = item.time_ms - cool_end_in;

   always_comb begin
      result.fall_detected = pulse;
      result.phase         = phase_in;
      result.fall_total    = count_in;
      result.cooling_down  = !is_clear && armed_in && cool_left[31];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         start_ff    <= '0;
         cool_end_ff <= '0;
         armed_ff    <= 1'b0;
         count_ff    <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         start_ff    <= start_in;
         cool_end_ff <= cool_end_in;
         armed_ff    <= armed_in;
         count_ff    <= count_in;
      end
   end

   a_pulse_counts: assert property (@(posedge clock) disable iff (reset)
      (step && pulse) |=> (count_ff == $past(count_ff) + 32'd1) && armed_ff)
      else $error("fall pulse did not bump the count and arm cooldown");

   a_clear_idles: assert property (@(posedge clock) disable iff (reset)
      (step && is_clear) |=> (phase_ff == PH_IDLE) && !armed_ff && (cool_end_ff == '0))
      else $error("clear left phase or cooldown set");

   a_hold_no_step: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(count_ff) && $stable(armed_ff))
      else $error("state moved without a transfer");

   a_pulse_idle: assert property (@(posedge clock) disable iff (reset)
      (step && pulse) |-> (phase_ff == PH_CONFIRM) && (phase_in == PH_IDLE))
      else $error("fall pulse outside confirm phase");

endmodule

[rtl/fall_detect_state_machine.sv]
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  kind, sample_valid, accel_mag_mg, tilt_sine_pct, time_ms
// rsp      out        rsp_valid/rsp_stall  fall_detected, phase, fall_total, cooling_down
// csr      in         csr_valid/csr_ready  csr_index (register number), csr_data
//
// One item per cycle sustained while rsp is not stalled; a req transfer reaches rsp valid
// through the input register, then the phase logic into the result register.
// Reset clears phase, timers, cooldown and fall count; registers take defaults.
// A stalled rsp holds the result register; req stalls only while the input
// register holds an item that cannot move into a still-occupied result register.
module fall_detect_state_machine
   import fds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic                  req_sample_valid,
   input  logic [15:0]           req_accel_mag_mg,
   input  logic [6:0]            req_tilt_sine_pct,
   input  logic [31:0]           req_time_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_fall_detected,
   output logic [1:0]            rsp_phase,
   output logic [31:0]           rsp_fall_total,
   output logic                  rsp_cooling_down,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type    cfg;
   logic       s1_valid_ff, s1_valid_in;
   item_type   s1_item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   result_type result;
   logic       advance;
   logic       accept;

   fds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // State advances only when the held item moves into the result register,
   // so back-to-back items always see the state left by the one before.
   fds_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (s1_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;   // transfer done, nothing new
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff.kind          <= req_kind;
         s1_item_ff.sample_valid  <= req_sample_valid;
         s1_item_ff.accel_mag_mg  <= req_accel_mag_mg;
         s1_item_ff.tilt_sine_pct <= req_tilt_sine_pct;
         s1_item_ff.time_ms       <= req_time_ms;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fall_detected = rsp_ff.fall_detected;
   assign rsp_phase         = rsp_ff.phase;
   assign rsp_fall_total    = rsp_ff.fall_total;
   assign rsp_cooling_down  = rsp_ff.cooling_down;

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> s1_valid_ff)
      else $error("held item dropped without moving to result");

   a_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !advance)
      else $error("stalled result overwritten");

   a_accept_free: assert property (@(posedge clock) disable iff (reset)
      accept |-> (!s1_valid_ff || advance))
      else $error("transfer into occupied input register");

endmodule
